// File: rtl/prc_pkg.sv
package prc_pkg;

  // Field widths of the item format and the default number of micro-rotations.
  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int DEF_ROTATION_STEPS = 16;

  // Internal datapath: guard fraction bits plus headroom for the CORDIC gain.
  localparam int GUARD_BITS = 4;
  localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 3;
  localparam int TURN_WIDTH = 32;
  localparam int KINV_BITS = 24;
  localparam int PROD_WIDTH = DATA_WIDTH + KINV_BITS + 1;
  localparam int NARROW_SHIFT = TURN_WIDTH - ANGLE_WIDTH;

  // Inverse CORDIC gain, scaled by 2^KINV_BITS.
  localparam logic [KINV_BITS-1:0] KINV = KINV_BITS'(10188014);

  localparam logic [TURN_WIDTH-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [TURN_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_WIDTH:0] ANGLE_RND = (33'd1 << NARROW_SHIFT) >> 1;

  // Conversion direction codes.
  localparam logic KIND_POLAR = 1'b0;
  localparam logic KIND_RECT = 1'b1;

  // Arctangent of 2^-i as a binary angle (2^32 is one turn).
  localparam logic [TURN_WIDTH-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] radius_in;
    logic [ANGLE_WIDTH-1:0]        angle_in;
  } in_item_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0]        radius_out;
    logic [ANGLE_WIDTH-1:0]        angle_out;
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
  } out_item_t;

  // Information that rides alongside the CORDIC data.
  typedef struct packed {
    logic                   kind;
    logic                   spec;
    logic [COORD_WIDTH-1:0] spec_mag;
    logic [ANGLE_WIDTH-1:0] spec_ang;
  } side_t;

  // One CORDIC stage: coordinates, angle accumulator and sideband.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic [TURN_WIDTH-1:0]        acc;
    side_t                        side;
  } rot_t;

  // Gain correction stage.
  typedef struct packed {
    logic signed [PROD_WIDTH-1:0] pa;
    logic signed [PROD_WIDTH-1:0] pb;
    logic [TURN_WIDTH-1:0]        acc;
    side_t                        side;
  } mul_t;

  // Round a full binary angle half up to the output width, wrapping at one turn.
  function automatic logic [ANGLE_WIDTH-1:0] narrow_angle(input logic [TURN_WIDTH-1:0] z);
    logic [TURN_WIDTH:0] sum;
    sum = {1'b0, z} + ANGLE_RND;
    return sum[NARROW_SHIFT +: ANGLE_WIDTH];
  endfunction

endpackage

// File: rtl/prc_rot_stage.sv
module prc_rot_stage
  import prc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic ld,
  input  logic prev_valid,
  input  rot_t prev_data,
  output logic valid_r,
  output rot_t data_r
);

  rot_t data_nxt;
  logic signed [DATA_WIDTH-1:0] da;
  logic signed [DATA_WIDTH-1:0] db;
  logic dir;

  // One micro-rotation. Vectoring steers by the sign of b, rotation by the
  // sign of the residual angle; both subtract the table angle when rotating counterclockwise.
  always_comb begin
    da = prev_data.b >>> STEP;
    db = prev_data.a >>> STEP;
    dir = (prev_data.side.kind == KIND_RECT) ? !prev_data.acc[TURN_WIDTH-1]
                                              : prev_data.b[DATA_WIDTH-1];
    data_nxt = prev_data;
    if (dir) begin
      data_nxt.a = prev_data.a - da;
      data_nxt.b = prev_data.b + db;
      data_nxt.acc = prev_data.acc - ATAN_TAB[STEP];
    end else begin
      data_nxt.a = prev_data.a + da;
      data_nxt.b = prev_data.b - db;
      data_nxt.acc = prev_data.acc + ATAN_TAB[STEP];
    end
  end

  // Stage register; the valid bit moves with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/polar_rectangular_converter_top.sv
// Pipelined CORDIC polar/rectangular converter.
// Stages: one setup stage, one stage per micro-rotation, a gain multiply and
// an output stage.
// Throughput: one item per cycle while out_stall is low; a stall only fills bubbles ahead of it.
// Reset clears the stage valid bits; data registers are not reset.
module polar_rectangular_converter_top
  import prc_pkg::*;
#(
  parameter int ROTATION_STEPS = DEF_ROTATION_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int GAIN_SHIFT = KINV_BITS + GUARD_BITS;
  localparam logic signed [PROD_WIDTH-1:0] GAIN_RND = PROD_WIDTH'(1) << (GAIN_SHIFT - 1);
  localparam logic signed [PROD_WIDTH-1:0] SMAX = PROD_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [PROD_WIDTH-1:0] SMIN = -SMAX - PROD_WIDTH'(1);
  localparam logic signed [PROD_WIDTH-1:0] UMAX = PROD_WIDTH'((1 << COORD_WIDTH) - 1);

  rot_t      pre_nxt;
  rot_t      pre_r;
  logic      pre_valid_r;
  logic      pre_rdy;
  rot_t      rot_data [ROTATION_STEPS];
  logic      rot_valid [ROTATION_STEPS];
  logic      rot_rdy [ROTATION_STEPS];
  mul_t      mul_nxt;
  mul_t      mul_r;
  logic      mul_valid_r;
  logic      mul_rdy;
  out_item_t out_nxt;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      out_rdy;

  // Ready chain: a stage may load when it is empty or the next one loads.
  assign out_rdy = !out_valid_r || !out_stall;
  assign mul_rdy = !mul_valid_r || out_rdy;
  assign pre_rdy = !pre_valid_r || rot_rdy[0];
  assign in_stall = !pre_rdy;

  // Setup: special cases, half-plane fold and angle fold into +-quarter turn.
  always_comb begin
    logic signed [DATA_WIDTH-1:0] xa;
    logic signed [DATA_WIDTH-1:0] ya;
    logic signed [DATA_WIDTH-1:0] ra;
    logic [TURN_WIDTH-1:0]        za;
    logic [TURN_WIDTH-1:0]        zq;
    pre_nxt = '0;
    pre_nxt.side.kind = in_data.kind;
    xa = DATA_WIDTH'(in_data.x_in);
    ya = DATA_WIDTH'(in_data.y_in);
    ra = DATA_WIDTH'(in_data.radius_in);
    za = TURN_WIDTH'(in_data.angle_in) << NARROW_SHIFT;
    zq = '0;
    if (in_data.kind == KIND_POLAR) begin
      if (in_data.x_in == '0) begin
        // On the y axis or at the origin.
        pre_nxt.side.spec = 1'b1;
        pre_nxt.side.spec_mag = in_data.y_in[COORD_WIDTH-1] ? COORD_WIDTH'(-in_data.y_in)
                                                             : COORD_WIDTH'(in_data.y_in);
        if (in_data.y_in == '0) begin
          pre_nxt.side.spec_ang = '0;
        end else if (in_data.y_in[COORD_WIDTH-1]) begin
          pre_nxt.side.spec_ang = narrow_angle(HALF_TURN + QUARTER_TURN);
        end else begin
          pre_nxt.side.spec_ang = narrow_angle(QUARTER_TURN);
        end
      end else if (in_data.y_in == '0) begin
        // On the x axis.
        pre_nxt.side.spec = 1'b1;
        pre_nxt.side.spec_mag = in_data.x_in[COORD_WIDTH-1] ? COORD_WIDTH'(-in_data.x_in)
                                                             : COORD_WIDTH'(in_data.x_in);
        pre_nxt.side.spec_ang = in_data.x_in[COORD_WIDTH-1] ? narrow_angle(HALF_TURN) : '0;
      end else begin
        // Left half plane is turned by a half turn before vectoring.
        if (in_data.x_in[COORD_WIDTH-1]) begin
          xa = -xa;
          ya = -ya;
          pre_nxt.acc = HALF_TURN;
        end
        pre_nxt.a = xa <<< GUARD_BITS;
        pre_nxt.b = ya <<< GUARD_BITS;
      end
    end else begin
      // Negative radius becomes positive with the angle turned by a half turn.
      if (in_data.radius_in[COORD_WIDTH-1]) begin
        ra = -ra;
        za = za + HALF_TURN;
      end
      // Angles outside +-quarter turn are folded by negating the radius.
      zq = za + QUARTER_TURN;
      if (zq >= HALF_TURN) begin
        ra = -ra;
        za = za - HALF_TURN;
      end
      pre_nxt.a = ra <<< GUARD_BITS;
      pre_nxt.b = '0;
      pre_nxt.acc = za;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (pre_rdy) begin
      pre_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_rdy) begin
      pre_r <= pre_nxt;
    end
  end

  // One register stage per micro-rotation.
  genvar k;
  generate
    for (k = 0; k < ROTATION_STEPS; k++) begin : g_rot
      if (k == ROTATION_STEPS - 1) begin : g_last
        assign rot_rdy[k] = !rot_valid[k] || mul_rdy;
      end else begin : g_mid
        assign rot_rdy[k] = !rot_valid[k] || rot_rdy[k+1];
      end
      if (k == 0) begin : g_first
        prc_rot_stage #(
          .STEP(k)
        ) u_stage (
          .clk       (clk),
          .rst_n     (rst_n),
          .ld        (rot_rdy[k]),
          .prev_valid(pre_valid_r),
          .prev_data (pre_r),
          .valid_r   (rot_valid[k]),
          .data_r    (rot_data[k])
        );
      end else begin : g_next
        prc_rot_stage #(
          .STEP(k)
        ) u_stage (
          .clk       (clk),
          .rst_n     (rst_n),
          .ld        (rot_rdy[k]),
          .prev_valid(rot_valid[k-1]),
          .prev_data (rot_data[k-1]),
          .valid_r   (rot_valid[k]),
          .data_r    (rot_data[k])
        );
      end
    end
  endgenerate

  // Gain correction products.
  always_comb begin
    mul_nxt.pa = PROD_WIDTH'(rot_data[ROTATION_STEPS-1].a) *
                 PROD_WIDTH'($signed({1'b0, KINV}));
    mul_nxt.pb = PROD_WIDTH'(rot_data[ROTATION_STEPS-1].b) *
                 PROD_WIDTH'($signed({1'b0, KINV}));
    mul_nxt.acc = rot_data[ROTATION_STEPS-1].acc;
    mul_nxt.side = rot_data[ROTATION_STEPS-1].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_rdy) begin
      mul_valid_r <= rot_valid[ROTATION_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_rdy) begin
      mul_r <= mul_nxt;
    end
  end

  // Round and saturate the scaled products; special polar cases use their stored results.
  always_comb begin
    logic signed [PROD_WIDTH-1:0] ga;
    logic signed [PROD_WIDTH-1:0] gb;
    ga = (mul_r.pa + GAIN_RND) >>> GAIN_SHIFT;
    gb = (mul_r.pb + GAIN_RND) >>> GAIN_SHIFT;
    out_nxt = '0;
    if (mul_r.side.kind == KIND_POLAR) begin
      if (mul_r.side.spec) begin
        out_nxt.radius_out = mul_r.side.spec_mag;
        out_nxt.angle_out = mul_r.side.spec_ang;
      end else begin
        if (ga < 0) begin
          out_nxt.radius_out = '0;
        end else if (ga > UMAX) begin
          out_nxt.radius_out = '1;
        end else begin
          out_nxt.radius_out = COORD_WIDTH'(ga);
        end
        out_nxt.angle_out = narrow_angle(mul_r.acc);
      end
    end else begin
      if (ga > SMAX) begin
        out_nxt.x_out = COORD_WIDTH'(SMAX);
      end else if (ga < SMIN) begin
        out_nxt.x_out = COORD_WIDTH'(SMIN);
      end else begin
        out_nxt.x_out = COORD_WIDTH'(ga);
      end
      if (gb > SMAX) begin
        out_nxt.y_out = COORD_WIDTH'(SMAX);
      end else if (gb < SMIN) begin
        out_nxt.y_out = COORD_WIDTH'(SMIN);
      end else begin
        out_nxt.y_out = COORD_WIDTH'(gb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
